[rtl/core/uvs_pkg.sv]
`timescale 1ns / 1ps
// uvs_pkg: operation and status codes, payload widths and the cell control
// struct for the unique value stack; depends on nothing
package uvs_pkg;

  localparam int unsigned ActionW = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 5;

  typedef logic [ActionW-1:0]        action_t;
  typedef logic signed [ValueW-1:0]  value_t;
  typedef logic [IndexW-1:0]         index_t;
  typedef logic [StatusW-1:0]        status_t;
  typedef logic [CountW-1:0]         count_t;

  // operation codes
  localparam action_t ACT_PUSH     = 3'd0;
  localparam action_t ACT_POP      = 3'd1;
  localparam action_t ACT_PEEK     = 3'd2;
  localparam action_t ACT_REMOVE   = 3'd3;
  localparam action_t ACT_CONTAINS = 3'd4;
  localparam action_t ACT_READ     = 3'd5;

  // result status codes
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_DUP      = 3'd1;
  localparam status_t ST_FULL     = 3'd2;
  localparam status_t ST_EMPTY    = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;
  localparam status_t ST_RANGE    = 3'd5;

  // per-cell update controls
  typedef struct packed {
    logic push_en;    // write the incoming value into this cell
    logic remove_en;  // a remove hit somewhere: cells at or above it close up
    logic live;       // this cell holds an entry below the fill count
  } cell_ctl_t;

endpackage

[rtl/core/uvs_if.sv]
`timescale 1ns / 1ps
// uvs_req_if and uvs_rsp_if: valid/ready channels of the unique value stack
// depends on uvs_pkg for payload types
interface uvs_req_if;
  logic               valid;
  logic               ready;
  uvs_pkg::action_t   action;
  uvs_pkg::value_t    value;
  uvs_pkg::index_t    index;

  modport source (output valid, action, value, index, input ready);
  modport sink   (input valid, action, value, index, output ready);
endinterface

interface uvs_rsp_if;
  logic               valid;
  logic               ready;
  uvs_pkg::value_t    data;
  logic               found;
  uvs_pkg::status_t   status;
  uvs_pkg::count_t    count;

  modport source (output valid, data, found, status, count, input ready);
  modport sink   (input valid, data, found, status, count, output ready);
endinterface

[rtl/core/uvs_cell.sv]
`timescale 1ns / 1ps
// uvs_cell: one stack entry with its own compare, hit chain and shift-down
// depends on uvs_pkg
module uvs_cell (
  input  logic               clk,
  input  uvs_pkg::cell_ctl_t ctl,
  input  uvs_pkg::value_t    value,
  input  uvs_pkg::value_t    upper_entry,
  input  logic               hit_in,
  output uvs_pkg::value_t    entry,
  output logic               hit_out
);
  import uvs_pkg::*;

  logic hit;

  // match against a live entry, carried up the row
  assign hit     = ctl.live && (entry == value);
  assign hit_out = hit_in || hit;

  // write on push, take the upper neighbor when closing up after a remove
  always_ff @(posedge clk) begin
    if (ctl.push_en) begin
      entry <= value;
    end else if (ctl.remove_en && hit_out) begin
      entry <= upper_entry;
    end
  end

endmodule

[rtl/core/unique_value_stack.sv]
`timescale 1ns / 1ps
// unique_value_stack: bounded stack of unique signed values built as a row
// of compare cells; depends on uvs_pkg, uvs_if and uvs_cell
//
//   channel  dir  payload                          item
//   req      in   action, value, index             one operation
//   rsp      out  data, found, status, count       one result per operation
//
// One item per cycle: the duplicate search, the close-up shift on remove and
// the indexed read all settle across the cell row in the accepting cycle.
// The result appears in the output register on the following cycle.
// req.ready stays high while the result register is empty or being taken,
// so a stalled rsp holds back only the next item.
// rst is synchronous; it empties the stack and the result register, and
// req.ready stays low while it is held.
module unique_value_stack #(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  uvs_req_if.sink   req,
  uvs_rsp_if.source rsp
);
  import uvs_pkg::*;

  localparam int unsigned FillW = $clog2(DEPTH + 1);
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CmpW  = (FillW > IndexW) ? FillW : IndexW;

  logic [FillW-1:0] fill;
  logic [FillW-1:0] fill_next;

  logic     rsp_valid;
  value_t   rsp_data;
  logic     rsp_found;
  status_t  rsp_status;
  count_t   rsp_count;

  value_t   data_next;
  logic     found_next;
  status_t  status_next;

  logic     accept;
  logic     present;
  logic     empty;
  logic     full;
  logic     push_ok;
  logic     remove_hit;
  logic     index_past_top;

  logic [CmpW-1:0]  fill_ext;
  logic [CmpW-1:0]  index_ext;
  logic [CmpW-1:0]  rd_depth;
  logic [AddrW-1:0] rd_addr;

  value_t     entries [DEPTH];
  logic       hit_chain [DEPTH+1];
  cell_ctl_t  ctl [DEPTH];

  // handshake
  assign req.ready = !rst && (!rsp_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign rsp.valid  = rsp_valid;
  assign rsp.data   = rsp_data;
  assign rsp.found  = rsp_found;
  assign rsp.status = rsp_status;
  assign rsp.count  = rsp_count;

  // stack status
  assign empty      = (fill == '0);
  assign full       = (fill == FillW'(DEPTH));
  assign present    = hit_chain[DEPTH];
  assign push_ok    = accept && (req.action == ACT_PUSH) && !present && !full;
  assign remove_hit = accept && (req.action == ACT_REMOVE) && present;

  // cell row
  assign hit_chain[0] = 1'b0;
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ctl[i].live      = (FillW'(i) < fill);
    assign ctl[i].push_en   = push_ok && (fill == FillW'(i));
    assign ctl[i].remove_en = remove_hit;

    uvs_cell u_cell (
      .clk         (clk),
      .ctl         (ctl[i]),
      .value       (req.value),
      .upper_entry ((i == DEPTH - 1) ? entries[i] : entries[(i + 1) % DEPTH]),
      .hit_in      (hit_chain[i]),
      .entry       (entries[i]),
      .hit_out     (hit_chain[i+1])
    );
  end

  // read position: top for pop and peek, top minus index for indexed read
  assign fill_ext       = CmpW'(fill);
  assign index_ext      = CmpW'(req.index);
  assign index_past_top = (index_ext >= fill_ext);
  assign rd_depth       = fill_ext - CmpW'(1)
                          - ((req.action == ACT_READ) ? index_ext : '0);
  assign rd_addr        = rd_depth[AddrW-1:0];

  // result and fill update
  always_comb begin
    data_next   = '0;
    found_next  = 1'b0;
    status_next = ST_OK;
    fill_next   = fill;
    case (req.action)
      ACT_PUSH: begin
        if (present) begin
          found_next  = 1'b1;
          status_next = ST_DUP;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          fill_next = fill + FillW'(1);
        end
      end
      ACT_POP: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          data_next = entries[rd_addr];
          fill_next = fill - FillW'(1);
        end
      end
      ACT_PEEK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          data_next = entries[rd_addr];
        end
      end
      ACT_REMOVE: begin
        if (present) begin
          found_next = 1'b1;
          fill_next  = fill - FillW'(1);
        end else begin
          status_next = ST_NOTFOUND;
        end
      end
      ACT_CONTAINS: begin
        found_next = present;
      end
      ACT_READ: begin
        if (index_past_top) begin
          status_next = ST_RANGE;
        end else begin
          data_next = entries[rd_addr];
        end
      end
      default: begin
      end
    endcase
  end

  // fill count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        fill      <= fill_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data   <= data_next;
      rsp_found  <= found_next;
      rsp_status <= status_next;
      rsp_count  <= CountW'(fill_next);
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking testbench for unique_value_stack, with its own stack predictor
// depends on uvs_pkg, uvs_if (uvs_req_if, uvs_rsp_if) and the unique_value_stack rtl
module tb;
  import uvs_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int STUCK_LIMIT = 3000;
  localparam int HOLD_LEN = 300;

  // action codes the block ignores
  localparam action_t ACT_SPARE6 = 3'd6;
  localparam action_t ACT_SPARE7 = 3'd7;

  localparam value_t VAL_MIN = 32'sh8000_0000;
  localparam value_t VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    value_t  data;
    logic    found;
    status_t status;
    count_t  count;
  } outcome_t;

  logic clk;
  logic rst;

  uvs_req_if req_ch ();
  uvs_rsp_if rsp_ch ();

  unique_value_stack #(.DEPTH(DEPTH)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  // predicted stack contents, bottom at index 0
  value_t   stack_mem [DEPTH];
  int       stack_fill;
  outcome_t pending [$];
  value_t   value_pool [32];

  bit bursty;
  int hold_asks;
  int hold_seen;
  int hold_left;
  int stuck;
  int n_sent;
  int n_checked;
  int n_errors;
  int peak_fill;
  int status_hits [6];

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // stack predictor: apply one operation, return the result it causes
  function automatic outcome_t apply_op(action_t act, value_t v, index_t ix);
    outcome_t r;
    int pos;
    r = '0;
    pos = -1;
    for (int i = 0; i < stack_fill; i++) begin
      if (pos < 0 && stack_mem[i] == v) pos = i;
    end
    case (act)
      ACT_PUSH: begin
        if (pos >= 0) begin
          r.found = 1'b1;
          r.status = ST_DUP;
        end else if (stack_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          stack_mem[stack_fill] = v;
          stack_fill++;
        end
      end
      ACT_POP: begin
        if (stack_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          stack_fill--;
          r.data = stack_mem[stack_fill];
        end
      end
      ACT_PEEK: begin
        if (stack_fill == 0) r.status = ST_EMPTY;
        else r.data = stack_mem[stack_fill - 1];
      end
      ACT_REMOVE: begin
        if (pos < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.found = 1'b1;
          for (int i = pos; i + 1 < stack_fill; i++) stack_mem[i] = stack_mem[i + 1];
          stack_fill--;
        end
      end
      ACT_CONTAINS: begin
        r.found = (pos >= 0);
      end
      ACT_READ: begin
        if (int'(ix) >= stack_fill) r.status = ST_RANGE;
        else r.data = stack_mem[stack_fill - 1 - int'(ix)];
      end
      default: begin
      end
    endcase
    r.count = count_t'(stack_fill);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    n_errors++;
    if (n_errors <= 40) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // offer one item, wait for it to be taken, record its expected result
  task automatic send_op(action_t act, value_t v, index_t ix);
    outcome_t want;
    while (bursty && $urandom_range(99) < 7) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.value  <= v;
    req_ch.index  <= ix;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    want = apply_op(act, v, ix);
    pending.push_back(want);
    n_sent++;
    status_hits[want.status]++;
    if (stack_fill > peak_fill) peak_fill = stack_fill;
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drain();
    req_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  // mostly values from a small pool so that duplicates and hits are common
  function automatic value_t pick_value();
    if ($urandom_range(9) == 0) return value_t'($urandom);
    return value_pool[$urandom_range(31)];
  endfunction

  function automatic index_t pick_index();
    if (stack_fill > 0 && $urandom_range(9) < 7) return index_t'($urandom_range(stack_fill - 1));
    return index_t'($urandom_range(15));
  endfunction

  function automatic value_t held_value();
    return stack_mem[$urandom_range(stack_fill - 1)];
  endfunction

  // directed: empty stack, extreme values, every action, out-of-range reads
  task automatic test_directed_edges();
    send_op(ACT_POP, 0, 0);
    send_op(ACT_PEEK, 0, 0);
    send_op(ACT_REMOVE, 5, 0);
    send_op(ACT_READ, 0, 0);
    send_op(ACT_PUSH, VAL_MIN, 0);
    send_op(ACT_PUSH, VAL_MAX, 15);
    send_op(ACT_PUSH, 0, 0);
    send_op(ACT_PUSH, -1, 0);
    send_op(ACT_PUSH, VAL_MAX, 0);
    send_op(ACT_CONTAINS, VAL_MIN, 0);
    send_op(ACT_CONTAINS, 1, 0);
    send_op(ACT_READ, 0, 0);
    send_op(ACT_READ, 0, 3);
    send_op(ACT_READ, 0, 4);
    send_op(ACT_READ, VAL_MAX, 15);
    send_op(ACT_PEEK, 0, 0);
    send_op(ACT_REMOVE, 0, 0);
    send_op(ACT_READ, 0, 1);
    send_op(ACT_REMOVE, 7, 0);
    send_op(ACT_POP, 0, 0);
    send_op(ACT_SPARE6, VAL_MIN, 15);
    send_op(ACT_SPARE7, -1, 9);
    send_op(ACT_POP, 0, 0);
    send_op(ACT_POP, 0, 0);
    send_op(ACT_POP, 0, 0);
  endtask

  // fill to the top, push into a full stack, then empty it again
  task automatic test_fill_and_drain(int rounds);
    for (int r = 0; r < rounds; r++) begin
      while (stack_fill < DEPTH) send_op(ACT_PUSH, value_t'($urandom), index_t'($urandom));
      send_op(ACT_PUSH, value_t'($urandom), 0);
      send_op(ACT_PUSH, held_value(), 0);
      send_op(ACT_READ, 0, index_t'(DEPTH - 1));
      send_op(ACT_READ, 0, 0);
      send_op(ACT_CONTAINS, held_value(), 0);
      while (stack_fill > 0) begin
        if ($urandom_range(1) == 0) send_op(ACT_POP, 0, 0);
        else send_op(ACT_REMOVE, held_value(), 0);
      end
      send_op(ACT_PEEK, 0, 0);
    end
  endtask

  // random operations, push rate steered by the current depth
  task automatic test_random_ops(int n);
    action_t act;
    value_t  v;
    int      push_pct;
    int      pick;
    for (int k = 0; k < n; k++) begin
      push_pct = (stack_fill < 4) ? 50 : (stack_fill > 12) ? 20 : 32;
      pick = $urandom_range(99);
      if (pick < push_pct) begin
        act = ACT_PUSH;
      end else begin
        pick = $urandom_range(99);
        if (pick < 18) act = ACT_POP;
        else if (pick < 33) act = ACT_PEEK;
        else if (pick < 55) act = ACT_REMOVE;
        else if (pick < 72) act = ACT_CONTAINS;
        else if (pick < 96) act = ACT_READ;
        else if (pick < 98) act = ACT_SPARE6;
        else act = ACT_SPARE7;
      end
      v = pick_value();
      if ((act == ACT_REMOVE || act == ACT_CONTAINS) && stack_fill > 0 && $urandom_range(1) == 0)
        v = held_value();
      send_op(act, v, pick_index());
    end
  endtask

  // back to back items with neither side idling
  task automatic test_no_idle_stretch(int n);
    bursty = 1'b0;
    test_random_ops(n);
    bursty = 1'b1;
  endtask

  // receiver holds off for a long stretch while items keep coming
  task automatic test_output_hold_off(int n);
    bursty = 1'b0;
    hold_asks++;
    test_random_ops(n);
    wait_drain();
    bursty = 1'b1;
  endtask

  // result receiver: random idling plus requested long hold-offs
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= !(bursty && $urandom_range(99) < 7);
    end
  end

  // result checker
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result with no operation outstanding, data %0d status %0d",
                                  rsp_ch.data, rsp_ch.status));
      end else begin
        want = pending.pop_front();
        if (rsp_ch.data !== want.data)
          report_mismatch($sformatf("result %0d data %0d, expected %0d",
                                    n_checked, rsp_ch.data, want.data));
        if (rsp_ch.found !== want.found)
          report_mismatch($sformatf("result %0d found %0b, expected %0b",
                                    n_checked, rsp_ch.found, want.found));
        if (rsp_ch.status !== want.status)
          report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                    n_checked, rsp_ch.status, want.status));
        if (rsp_ch.count !== want.count)
          report_mismatch($sformatf("result %0d count %0d, expected %0d",
                                    n_checked, rsp_ch.count, want.count));
      end
      n_checked++;
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               STUCK_LIMIT, pending.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  // test sequence
  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_PUSH;
    req_ch.value = '0;
    req_ch.index = '0;
    rsp_ch.ready = 1'b0;
    bursty = 1'b1;
    hold_asks = 0;
    hold_seen = 0;
    hold_left = 0;
    stuck = 0;
    n_sent = 0;
    n_checked = 0;
    n_errors = 0;
    peak_fill = 0;
    stack_fill = 0;
    foreach (status_hits[i]) status_hits[i] = 0;
    foreach (stack_mem[i]) stack_mem[i] = '0;
    value_pool[0] = VAL_MIN;
    value_pool[1] = VAL_MAX;
    value_pool[2] = 0;
    value_pool[3] = -1;
    for (int i = 4; i < 32; i++) value_pool[i] = value_t'($urandom);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_fill_and_drain(3);
    test_no_idle_stretch(200);
    test_output_hold_off(60);
    test_random_ops(1250);
    test_fill_and_drain(1);

    wait_drain();
    repeat (4) @(posedge clk);

    $display("%0d operations sent, %0d results checked, %0d mismatches, deepest stack %0d",
             n_sent, n_checked, n_errors, peak_fill);
    $display("status mix: ok %0d, dup %0d, full %0d, empty %0d, not found %0d, range %0d",
             status_hits[ST_OK], status_hits[ST_DUP], status_hits[ST_FULL],
             status_hits[ST_EMPTY], status_hits[ST_NOTFOUND], status_hits[ST_RANGE]);
    if (n_errors == 0 && pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/uvs_pkg.sv
rtl/core/uvs_if.sv
rtl/core/uvs_cell.sv
rtl/core/unique_value_stack.sv
tb/tb.sv
